### hw/rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int VC_W   = $clog2(DEPTH + 1);

    localparam int KEY_W  = 32;
    localparam int USE_W  = 16;
    localparam int CAP_W  = 4;
    localparam int POS_W  = 3;
    localparam int OCC_W  = 4;

    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(8);
    localparam logic [USE_W-1:0] USE_MAX     = {USE_W{1'b1}};
    localparam logic             FUNC_ACCESS = 1'b0;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic                    hit;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] front_key;
        logic [OCC_W-1:0]        occupancy;
    } out_item_t;

    // running result handed from cell to cell during the search
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_pos;
        logic [USE_W-1:0] hit_cnt;
        logic             min_ok;
        logic [IDX_W-1:0] min_pos;
        logic [USE_W-1:0] min_cnt;
    } srch_t;

endpackage

### hw/rtl/lfu_cell.sv
module lfu_cell (
    input  logic                         clk,
    input  logic [lfu_pkg::IDX_W-1:0]    idx,
    input  logic                         active,
    input  logic [lfu_pkg::KEY_W-1:0]    key_q,
    input  logic                         shift_en,
    input  logic [lfu_pkg::KEY_W-1:0]    shift_key,
    input  logic [lfu_pkg::USE_W-1:0]    shift_cnt,
    input  lfu_pkg::srch_t               chain_in,
    output lfu_pkg::srch_t               chain_out,
    output logic [lfu_pkg::KEY_W-1:0]    key_out,
    output logic [lfu_pkg::USE_W-1:0]    cnt_out
);
    import lfu_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [USE_W-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg <= shift_key;
            cnt_reg <= shift_cnt;
        end
    end

    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.found && active && (key_reg == key_q))
        begin
            chain_out.found   = 1'b1;
            chain_out.hit_pos = idx;
            chain_out.hit_cnt = cnt_reg;
        end
        // strict compare: on a tie the earlier cell keeps it
        if (active && (!chain_in.min_ok || (cnt_reg < chain_in.min_cnt)))
        begin
            chain_out.min_ok  = 1'b1;
            chain_out.min_pos = idx;
            chain_out.min_cnt = cnt_reg;
        end
    end

    assign key_out = key_reg;
    assign cnt_out = cnt_reg;

endmodule

### hw/rtl/lfu_replacement_cache.sv
// LFU replacement store: a row of key/use-count cells, position 0 the newest.
// Input channel in_valid/in_ready/in_data carries one item: func (access or
// lookup) and key. Output channel out_valid/out_ready/out_data returns one
// item per input: hit, position, front key and occupancy after the step.
// cfg_valid/cfg_ready/cfg_data writes the capacity register; cfg_ready is
// always high, and writes belong to idle periods only.
// Each item passes the search (match and least-used scan ripple along the
// cell row) and then the shift, where for an access the cells up to the
// chosen slot move one place back and cell 0 takes the key; out_valid rises
// as the shift commits. While the output is taken, the next item is accepted
// only once the last one is in its shift: its search must see the shifted row.
// The result sits in an output register, so one result may wait while the
// next item is already accepted and searched; the shift of that next item
// holds until the waiting result is taken.
// Reset empties the store (occupancy 0), sets capacity to 8 and clears the
// output valid; the cell contents themselves are not cleared.
module lfu_replacement_cache (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lfu_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lfu_pkg::out_item_t           out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]    cfg_data
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_SHIFT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [VC_W-1:0]  vc_reg, vc_next;
    in_item_t         item_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;

    logic             s_hit_reg;
    logic [IDX_W-1:0] s_pos_reg;
    logic [IDX_W-1:0] s_slot_reg;
    logic [USE_W-1:0] s_cnt_reg;
    logic             s_grow_reg;

    logic [KEY_W-1:0] key_w [DEPTH];
    logic [USE_W-1:0] cnt_w [DEPTH];
    srch_t            chain [DEPTH+1];

    logic             out_free;
    logic             accept;
    logic             commit;
    logic [VC_W-1:0]  eff_cap;
    logic             grow;
    logic [IDX_W-1:0] slot;
    logic [USE_W-1:0] new_cnt;
    logic             do_shift;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_SHIFT) && out_free);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == ST_SHIFT) && out_free;
    assign cfg_ready = 1'b1;
    assign do_shift  = commit && (item_reg.func == FUNC_ACCESS);

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = VC_W'(1);
        else if (32'(cap_reg) > DEPTH)
            eff_cap = VC_W'(DEPTH);
        else
            eff_cap = VC_W'(cap_reg);
    end

    assign chain[0] = '0;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic             active;
        logic             sh_en;
        logic [KEY_W-1:0] sh_key;
        logic [USE_W-1:0] sh_cnt;

        assign active = (VC_W'(j) < vc_reg);
        assign sh_en  = do_shift && (IDX_W'(j) <= s_slot_reg);

        if (j == 0)
        begin : g_head
            assign sh_key = item_reg.key;
            assign sh_cnt = s_cnt_reg;
        end
        else
        begin : g_body
            assign sh_key = key_w[j-1];
            assign sh_cnt = cnt_w[j-1];
        end

        lfu_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(j)),
            .active    (active),
            .key_q     (item_reg.key),
            .shift_en  (sh_en),
            .shift_key (sh_key),
            .shift_cnt (sh_cnt),
            .chain_in  (chain[j]),
            .chain_out (chain[j+1]),
            .key_out   (key_w[j]),
            .cnt_out   (cnt_w[j])
        );
    end

    // end of the cell row: where the item goes and with what count
    always_comb
    begin
        grow = 1'b0;
        if (chain[DEPTH].found)
        begin
            slot    = chain[DEPTH].hit_pos;
            new_cnt = (chain[DEPTH].hit_cnt == USE_MAX) ? USE_MAX
                                                        : chain[DEPTH].hit_cnt + USE_W'(1);
        end
        else
        begin
            new_cnt = USE_W'(1);
            if (vc_reg < eff_cap)
            begin
                slot = vc_reg[IDX_W-1:0];
                grow = 1'b1;
            end
            else
                slot = chain[DEPTH].min_pos;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        vc_next        = vc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.func == FUNC_ACCESS && s_grow_reg)
                        vc_next = vc_reg + VC_W'(1);
                    state_next = accept ? ST_SEARCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            vc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        if (state_reg == ST_SEARCH)
        begin
            s_hit_reg  <= chain[DEPTH].found;
            s_pos_reg  <= chain[DEPTH].found ? chain[DEPTH].hit_pos : '0;
            s_slot_reg <= slot;
            s_cnt_reg  <= new_cnt;
            s_grow_reg <= grow;
        end
        if (commit)
        begin
            out_data_reg.hit       <= s_hit_reg;
            out_data_reg.position  <= POS_W'(s_pos_reg);
            out_data_reg.occupancy <= OCC_W'(vc_next);
            if (item_reg.func == FUNC_ACCESS)
                out_data_reg.front_key <= item_reg.key;
            else if (vc_reg != '0)
                out_data_reg.front_key <= key_w[0];
            else
                out_data_reg.front_key <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vc_reg) <= DEPTH)
        else $error("occupancy beyond depth");

    a_vc_mono: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg >= $past(vc_reg))
        else $error("occupancy decreased");

    a_search_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |=> state_reg == ST_SHIFT)
        else $error("search not followed by shift");

    a_out_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SHIFT))
        else $error("result raised outside shift");

    a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && s_hit_reg |-> (s_slot_reg == s_pos_reg) && !s_grow_reg)
        else $error("hit moved from wrong slot");

endmodule

### bench/tb_top.sv
module tb_top;
    import lfu_pkg::*;

    localparam logic FUNC_LOOKUP   = 1'b1;
    localparam int   CYCLE_LIMIT   = 2_000_000;
    localparam int   HEAVY_ACCESSES = 89;
    localparam int   RAND_PHASES   = 6;
    localparam int   PHASE_ITEMS   = 150;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    lfu_replacement_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic signed [KEY_W-1:0] key_store [DEPTH];
    logic [USE_W-1:0]        use_cnt   [DEPTH];
    int                      fill;
    logic [CAP_W-1:0]        cap_reg;

    out_item_t   expected_results [$];
    out_item_t   want;
    int unsigned err_count;
    int unsigned cycle_count;

    // sender / receiver shaping
    bit          tx_bursty;
    int          burst_left;
    int          rx_mode;
    int          rx_hold;
    logic [15:0] rx_pat;
    int          rx_tick;

    always #10 clk = ~clk;

    function automatic out_item_t lfu_predict(logic f, logic signed [KEY_W-1:0] k);
        out_item_t        r;
        int               eff;
        int               pos;
        int               slot;
        logic [USE_W-1:0] cnt;
        logic [USE_W-1:0] minc;

        eff = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        pos = -1;
        for (int i = 0; i < fill; i++)
            if (pos < 0 && key_store[i] == k)
                pos = i;

        if (f == FUNC_ACCESS) begin
            if (pos >= 0) begin
                cnt  = (use_cnt[pos] == USE_MAX) ? USE_MAX : use_cnt[pos] + 1'b1;
                slot = pos;
            end
            else begin
                cnt = USE_W'(1);
                if (fill < eff) begin
                    slot = fill;
                    fill++;
                end
                else begin
                    // least used wins, ties go to the lowest position
                    slot = 0;
                    minc = use_cnt[0];
                    for (int i = 1; i < fill; i++)
                        if (use_cnt[i] < minc) begin
                            minc = use_cnt[i];
                            slot = i;
                        end
                end
            end
            for (int j = slot; j > 0; j--) begin
                key_store[j] = key_store[j-1];
                use_cnt[j]   = use_cnt[j-1];
            end
            key_store[0] = k;
            use_cnt[0]   = cnt;
        end

        r.hit       = (pos >= 0);
        r.position  = (pos >= 0) ? POS_W'(pos) : '0;
        r.front_key = (fill > 0) ? key_store[0] : '0;
        r.occupancy = OCC_W'(fill);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        err_count++;
        $display("ERROR @%0d: %s got %0h exp %0h", cycle_count, what, got, exp_val);
    endtask

    // one item on the input channel; prediction happens at acceptance
    task automatic send_item(logic f, logic signed [KEY_W-1:0] k);
        int gap;

        gap = 0;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(1, 5);
            end
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     = 1'b1;
        in_data.func = f;
        in_data.key  = k;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(lfu_predict(f, k));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cap_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: long hold-off first, then its stall pattern
    always @(negedge clk) begin
        rx_tick++;
        if (rx_tick % 48 == 0)
            rx_pat = 16'($urandom) | 16'h0101;
        if (rx_hold > 0) begin
            out_ready = 1'b0;
            rx_hold--;
        end
        else if (rx_mode == 0)
            out_ready = 1'b1;
        else if (rx_mode == 1) begin
            out_ready = rx_pat[0];
            rx_pat    = {rx_pat[0], rx_pat[15:1]};
        end
        else
            out_ready = ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'(out_data.front_key), 32'd0);
            else begin
                want = expected_results.pop_front();
                if (out_data.hit !== want.hit)
                    report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
                if (out_data.position !== want.position)
                    report_mismatch("position", 32'(out_data.position),
                                    32'(want.position));
                if (out_data.front_key !== want.front_key)
                    report_mismatch("front_key", 32'(out_data.front_key),
                                    32'(want.front_key));
                if (out_data.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(out_data.occupancy),
                                    32'(want.occupancy));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lfu_replacement_cache: mismatch");
            $finish;
        end
    end

    // capacity zero acts as one, above DEPTH saturates, lowering keeps entries
    task automatic test_capacity_edges();
        set_capacity(CAP_W'(0));
        send_item(FUNC_LOOKUP, 32'sd7);
        send_item(FUNC_ACCESS, 32'sd7);
        send_item(FUNC_ACCESS, 32'sd9);
        send_item(FUNC_LOOKUP, 32'sd7);
        send_item(FUNC_ACCESS, 32'sd9);
        set_capacity(CAP_W'(15));
        for (int i = 0; i < 9; i++)
            send_item(FUNC_ACCESS, 32'sd100 + i);
        set_capacity(CAP_W'(3));
        send_item(FUNC_ACCESS, 32'sd200);
        send_item(FUNC_ACCESS, 32'sd201);
        set_capacity(CAP_W'(1));
        send_item(FUNC_ACCESS, 32'sd202);
        set_capacity(CAP_W'(8));
    endtask

    task automatic test_key_extremes();
        send_item(FUNC_ACCESS, 32'sh8000_0000);
        send_item(FUNC_ACCESS, 32'sh7FFF_FFFF);
        send_item(FUNC_ACCESS, 32'sh0000_0000);
        send_item(FUNC_ACCESS, 32'shFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'sh7FFF_FFFF);
        send_item(FUNC_LOOKUP, 32'sh0000_3039);
        send_item(FUNC_ACCESS, 32'sh7FFF_FFFF);
        send_item(FUNC_ACCESS, 32'sh8000_0000);
        send_item(FUNC_ACCESS, 32'sh0000_0063);
        send_item(FUNC_ACCESS, 32'sh0000_0000);
        send_item(FUNC_ACCESS, 32'sh0000_0064);
        send_item(FUNC_LOOKUP, 32'shFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'sh8000_0000);
    endtask

    task automatic test_output_holdoff();
        drain_results();
        rx_mode = 0;
        tx_bursty = 0;
        rx_hold = 300;
        for (int i = 0; i < 20; i++)
            send_item(i[0] ? FUNC_LOOKUP : FUNC_ACCESS, $urandom_range(0, 11));
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic signed [KEY_W-1:0] pool [16];
        int                      pool_n;
        logic signed [KEY_W-1:0] k;
        logic                    f;

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_capacity(CAP_W'(1));
                1:       set_capacity(CAP_W'(15));
                2:       set_capacity(CAP_W'(0));
                3:       set_capacity(CAP_W'(8));
                default: set_capacity(CAP_W'($urandom_range(0, 15)));
            endcase
            tx_bursty = (p != 0);
            rx_mode   = (p == 0) ? 0 : $urandom_range(1, 2);
            pool_n    = $urandom_range(9, 16);
            for (int i = 0; i < pool_n; i++)
                pool[i] = (i < 4) ? $urandom_range(0, 15) : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                f = ($urandom_range(0, 3) == 0) ? FUNC_LOOKUP : FUNC_ACCESS;
                k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
                send_item(f, k);
            end
        end
    endtask

    // build a high use count on one key, then push fresh keys past it
    task automatic test_high_count();
        drain_results();
        tx_bursty = 0;
        rx_mode   = 0;
        for (int i = 0; i < HEAVY_ACCESSES; i++)
            send_item(FUNC_ACCESS, 32'sh5A5A_0001);
        for (int i = 0; i < 10; i++)
            send_item(FUNC_ACCESS, 32'sh0BAD_0000 + i);
        send_item(FUNC_LOOKUP, 32'sh5A5A_0001);
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        err_count   = 0;
        cycle_count = 0;
        tx_bursty   = 1'b0;
        burst_left  = 0;
        rx_mode     = 0;
        rx_hold     = 0;
        rx_pat      = 16'hA5C3;
        rx_tick     = 0;
        fill        = 0;
        cap_reg     = CAP_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            key_store[i] = '0;
            use_cnt[i]   = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_capacity_edges();
        rx_mode = 1;
        tx_bursty = 1;
        test_key_extremes();
        test_output_holdoff();
        test_random_traffic();
        test_high_count();

        drain_results();
        if (err_count == 0)
            $display("lfu_replacement_cache: match");
        else
            $display("lfu_replacement_cache: mismatch");
        $finish;
    end

endmodule

### files.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_replacement_cache.sv
bench/tb_top.sv
